// ===== hdl/assert_macros.svh =====
// ---------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros, clocked on clk, disabled in reset.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/ttd_pkg.sv =====
// ---------------------------------------------------------------------------
// ttd_pkg
// Types, codes and constants of the transposition table decipher block.
// ---------------------------------------------------------------------------
package ttd_pkg;

    localparam int DIM_W     = 12;
    localparam int POS_W     = 22;
    localparam int CHAR_W    = 8;
    localparam int ACTION_W  = 2;
    localparam int CFG_IDX_W = 2;
    localparam logic [DIM_W-1:0] MAX_DIM = 12'd2048;

    localparam logic [CFG_IDX_W-1:0] CFG_ROW_COUNT    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COLUMN_COUNT = 2'd1;

    localparam logic [CHAR_W-1:0] CHAR_UNDERSCORE = 8'h5F;
    localparam logic [CHAR_W-1:0] CHAR_BACKSLASH  = 8'h5C;
    localparam logic [CHAR_W-1:0] CHAR_SPACE      = 8'h20;
    localparam logic [CHAR_W-1:0] CHAR_NEWLINE    = 8'h0A;

    typedef enum logic [ACTION_W-1:0] {
        ACT_LOAD  = 2'd0,
        ACT_FETCH = 2'd1,
        ACT_START = 2'd2
    } action_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD_MUL,
        ST_LOAD_WR,
        ST_FETCH_OUT
    } state_t;

    typedef struct packed {
        logic start;
        logic load_step;
        logic mul;
        logic write;
        logic fetch_rd;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic load_hit;
        logic out_free;
    } status_t;

    function automatic logic [CHAR_W-1:0] map_char(input logic [CHAR_W-1:0] c);
        logic [CHAR_W-1:0] m;
        m = c;
        if (c == CHAR_UNDERSCORE)
        begin
            m = CHAR_SPACE;
        end
        else if (c == CHAR_BACKSLASH)
        begin
            m = CHAR_NEWLINE;
        end
        return m;
    endfunction

endpackage

// ===== hdl/ttd_ctrl.sv =====
// ---------------------------------------------------------------------------
// ttd_ctrl
// Sequencer: accepts items and steps the datapath through start, load and fetch.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module ttd_ctrl (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic [ttd_pkg::ACTION_W-1:0] action,
    input  ttd_pkg::status_t          status,
    output ttd_pkg::cmd_t             cmd
);
    import ttd_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        s_tready   = 1'b0;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    case (action_t'(action))
                        ACT_LOAD:
                        begin
                            cmd.load_step = 1'b1;
                            if (status.load_hit)
                            begin
                                state_next = ST_LOAD_MUL;
                            end
                        end
                        ACT_FETCH:
                        begin
                            cmd.fetch_rd = 1'b1;
                            state_next   = ST_FETCH_OUT;
                        end
                        ACT_START:
                        begin
                            cmd.start = 1'b1;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_LOAD_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = ST_LOAD_WR;
            end
            ST_LOAD_WR:
            begin
                cmd.write  = 1'b1;
                state_next = ST_IDLE;
            end
            ST_FETCH_OUT:
            begin
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // a pending result is never overwritten
    `ASSERT_IMPL(a_out_load_free, cmd.out_load, status.out_free, "result overwritten")
    // a load that finds a cell always reaches the write step
    `ASSERT_NEXT(a_mul_to_wr, state_reg == ST_LOAD_MUL, cmd.write, "load write missed")

endmodule

// ===== hdl/ttd_datapath.sv =====
// ---------------------------------------------------------------------------
// ttd_datapath
// Geometry registers, load counters, position multiplier, message store,
// read pointer, trimmed length and output register.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module ttd_datapath #(
    parameter int CAPACITY = 2048
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  logic [ttd_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [ttd_pkg::DIM_W-1:0]    cfg_data,
    input  logic [ttd_pkg::CHAR_W-1:0]   char_in,
    input  ttd_pkg::cmd_t                cmd,
    output ttd_pkg::status_t             status,
    input  logic                         m_tready,
    output logic                         m_tvalid,
    output logic [ttd_pkg::CHAR_W-1:0]   m_tdata,
    output logic                         m_tuser,
    output logic                         m_tlast
);
    import ttd_pkg::*;

    localparam int AW = $clog2(CAPACITY);
    localparam int LW = $clog2(CAPACITY + 1);
    localparam logic [POS_W-1:0] CAP_POS = POS_W'(CAPACITY);

    logic [DIM_W-1:0]  rows_reg;
    logic [DIM_W-1:0]  cols_reg;
    logic [DIM_W-1:0]  lcol_reg;
    logic [DIM_W-1:0]  lrow_reg;
    logic [DIM_W-1:0]  cell_col_reg;
    logic [DIM_W-1:0]  cell_row_reg;
    logic [CHAR_W-1:0] char_reg;
    logic [POS_W-1:0]  prod_reg;
    logic [DIM_W-1:0]  row_term_reg;
    logic [LW-1:0]     tlen_reg;
    logic [LW-1:0]     rpos_reg;
    logic [CHAR_W-1:0] rd_data_reg;
    logic              fetch_hit_reg;
    logic              fetch_last_reg;
    logic              m_tvalid_reg;
    logic [CHAR_W-1:0] out_char_reg;
    logic              out_user_reg;
    logic              out_last_reg;

    logic [CHAR_W-1:0] mem [CAPACITY];

    logic [DIM_W-1:0] dim_sat;
    logic             geom_zero;
    logic             wrap_a;
    logic [DIM_W-1:0] lcol_a;
    logic [DIM_W-1:0] lrow_a;
    logic             load_hit;
    logic [DIM_W-1:0] lcol_b;
    logic             wrap_b;
    logic [DIM_W-1:0] col_term;
    logic [POS_W-1:0] pos;
    logic             pos_in_range;
    logic             fetch_hit;
    logic [LW-1:0]    rpos_inc;
    logic [2*DIM_W-1:0] prod_full;

    assign dim_sat   = (cfg_data > MAX_DIM) ? MAX_DIM : cfg_data;
    assign geom_zero = (rows_reg == '0) || (cols_reg == '0);
    assign wrap_a    = (lcol_reg >= cols_reg);
    assign lcol_a    = wrap_a ? '0 : lcol_reg;
    assign lrow_a    = wrap_a ? lrow_reg + 1'b1 : lrow_reg;
    assign load_hit  = !geom_zero && (lrow_a < rows_reg);
    assign lcol_b    = lcol_a + 1'b1;
    assign wrap_b    = (lcol_b >= cols_reg);

    assign col_term  = cols_reg - 1'b1 - cell_col_reg;
    assign prod_full = col_term * rows_reg;
    assign pos       = prod_reg + POS_W'(row_term_reg);
    assign pos_in_range = (pos < CAP_POS);

    assign fetch_hit = (rpos_reg < tlen_reg);
    assign rpos_inc  = rpos_reg + 1'b1;

    assign status.load_hit = load_hit;
    assign status.out_free = !m_tvalid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_reg <= DIM_W'(1);
            cols_reg <= DIM_W'(1);
        end
        else if (cfg_we)
        begin
            if (cfg_index == CFG_ROW_COUNT)
            begin
                rows_reg <= dim_sat;
            end
            else if (cfg_index == CFG_COLUMN_COUNT)
            begin
                cols_reg <= dim_sat;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lcol_reg <= '0;
            lrow_reg <= '0;
            tlen_reg <= '0;
            rpos_reg <= '0;
        end
        else if (cmd.start)
        begin
            lcol_reg <= '0;
            lrow_reg <= '0;
            tlen_reg <= '0;
            rpos_reg <= '0;
        end
        else
        begin
            if (cmd.load_step && !geom_zero)
            begin
                if (load_hit)
                begin
                    lcol_reg <= wrap_b ? '0 : lcol_b;
                    lrow_reg <= wrap_b ? lrow_a + 1'b1 : lrow_a;
                end
                else
                begin
                    lcol_reg <= lcol_a;
                    lrow_reg <= lrow_a;
                end
            end
            if (cmd.write && pos_in_range && (char_reg != CHAR_SPACE)
                && (pos >= POS_W'(tlen_reg)))
            begin
                tlen_reg <= LW'(pos + 1'b1);
            end
            if (cmd.fetch_rd && fetch_hit)
            begin
                rpos_reg <= rpos_inc;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_step)
        begin
            cell_col_reg <= lcol_a;
            cell_row_reg <= lrow_a;
            char_reg     <= map_char(char_in);
        end
        if (cmd.mul)
        begin
            prod_reg     <= prod_full[POS_W-1:0];
            row_term_reg <= rows_reg - 1'b1 - cell_row_reg;
        end
        if (cmd.fetch_rd)
        begin
            fetch_hit_reg  <= fetch_hit;
            fetch_last_reg <= fetch_hit && (rpos_inc == tlen_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.write && pos_in_range)
        begin
            mem[pos[AW-1:0]] <= char_reg;
        end
        if (cmd.fetch_rd)
        begin
            rd_data_reg <= mem[rpos_reg[AW-1:0]];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            m_tvalid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_char_reg <= fetch_hit_reg ? rd_data_reg : '0;
            out_user_reg <= fetch_hit_reg;
            out_last_reg <= fetch_last_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = out_char_reg;
    assign m_tuser  = out_user_reg;
    assign m_tlast  = out_last_reg;

    `ASSERT_IMPL(a_rpos_le_tlen, 1'b1, rpos_reg <= tlen_reg, "read pointer past length")
    `ASSERT_IMPL(a_tlen_le_cap, 1'b1, tlen_reg <= LW'(CAPACITY), "length past capacity")
    `ASSERT_IMPL(a_last_valid, m_tvalid && m_tlast, m_tuser, "last flag without char")

endmodule

// ===== hdl/transposition_table_decipher_top.sv =====
// Load: a load whose cell lies in the table runs accept, multiply and write steps, else only accept.
// Fetch: the store read is registered at accept, and the result register is loaded from it
// in the fetch-out state once the output is free; a stalled result holds off the next item.
// Start and unused actions finish at accept. One item at a time: items are taken only in idle.
// Reset clears geometry to 1x1, counters, length, read pointer and output valid;
// the message store is not cleared.
// ---------------------------------------------------------------------------
// transposition_table_decipher_top
// Columnar transposition decipher: loads fragments, emits trimmed message.
// ---------------------------------------------------------------------------
module transposition_table_decipher_top #(
    parameter int CAPACITY = 2048
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [15:0]                   s_tdata,   // action[1:0], char_in[9:2], zero fill
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [7:0]                    m_tdata,   // char_out[7:0]
    output logic                          m_tuser,   // out_valid
    output logic                          m_tlast,   // is_last
    input  logic                          cfg_we,
    input  logic [ttd_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [ttd_pkg::DIM_W-1:0]     cfg_data
);
    import ttd_pkg::*;

    cmd_t    cmd;
    status_t status;
    logic [ACTION_W-1:0] action;
    logic [CHAR_W-1:0]   char_in;

    assign action  = s_tdata[ACTION_W-1:0];
    assign char_in = s_tdata[ACTION_W+CHAR_W-1:ACTION_W];

    ttd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .action   (action),
        .status   (status),
        .cmd      (cmd)
    );

    ttd_datapath #(
        .CAPACITY (CAPACITY)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .char_in   (char_in),
        .cmd       (cmd),
        .status    (status),
        .m_tready  (m_tready),
        .m_tvalid  (m_tvalid),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

endmodule
